[hdl/sda_pkg.sv]
// Shared types and constants of the sequencer dispatch allocator.
package sda_pkg;

   localparam int NUM_SEQUENCERS_DEFAULT = 8;
   localparam int MAX_PORTS = 8;       // ports addressable by the 3-bit index and the mask
   localparam int IDX_W = 3;
   localparam int MASK_W = 8;
   localparam int TAG_W = 16;
   localparam int WORD_W = 32;
   localparam int CODE_W = 3;
   localparam int AVAIL_W = 4;

   typedef enum logic [1:0] {
      MODE_RUN       = 2'd0,
      MODE_RUN_NORSP = 2'd1,
      MODE_STARTED   = 2'd2,
      MODE_DONE      = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE      = 2'd0,
      ST_RUN_FREE  = 2'd1,
      ST_RUN_BLOCK = 2'd2
   } entry_state_type;

   localparam logic [CODE_W-1:0] RESP_OK       = 3'd0;
   localparam logic [CODE_W-1:0] RESP_EXEC_ERR = 3'd4;

   localparam logic [CODE_W-1:0] WARN_NONE        = 3'd0;
   localparam logic [CODE_W-1:0] WARN_NO_SEQ      = 3'd1;
   localparam logic [CODE_W-1:0] WARN_CONFLICT    = 3'd2;
   localparam logic [CODE_W-1:0] WARN_UNEXPECTED  = 3'd3;
   localparam logic [CODE_W-1:0] WARN_UNKNOWN_FIN = 3'd4;

   typedef enum logic [1:0] {
      CTL_IDLE  = 2'd0,
      CTL_SCAN  = 2'd1,
      CTL_APPLY = 2'd2,
      CTL_SEND  = 2'd3
   } ctl_state_type;

   typedef struct packed {
      logic capture;
      logic scan;
      logic apply;
   } dp_cmd_type;

endpackage

[hdl/sequencer_dispatch_allocator_core.sv]
// Top level of the sequencer dispatch allocator.
//
// Request channel (req_*): run commands, run requests without response, and
// started / done reports from the sequencers. A transfer happens when req_valid
// is high and req_stall is low. Result channel (rsp_*): one result per request,
// carrying the command response, the dispatch, a warning code and the counters.
// Configuration: csr_write_enable / csr_write_data load the connected mask;
// write it only while no request is in flight.
//
// Timing: the request is captured at its transfer edge; the controller then scans
// the table over all entries in parallel (SCAN), updates it (APPLY) and raises
// rsp_valid (SEND). The next request is taken in the cycle after the result
// transfer, so no new request is taken before the last one is through; the
// four-state controller sets this order.
// While rsp_stall is high the result holds and req_stall stays high.
// Reset (synchronous, active high) marks every sequencer idle with tag 0, sets
// the available count to NUM_SEQUENCERS, clears both counters and sets the mask
// to all ones.
module sequencer_dispatch_allocator_core #(
   parameter int NUM_SEQUENCERS = sda_pkg::NUM_SEQUENCERS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [sda_pkg::MASK_W-1:0]    csr_write_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_mode,
   input  logic [sda_pkg::WORD_W-1:0]    req_opcode,
   input  logic [sda_pkg::WORD_W-1:0]    req_cmd_seq,
   input  logic [sda_pkg::TAG_W-1:0]     req_sequence_id,
   input  logic                          req_wait_for_done,
   input  logic [sda_pkg::IDX_W-1:0]     req_sequencer_index,
   input  logic [sda_pkg::CODE_W-1:0]    req_done_response,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_respond_valid,
   output logic [sda_pkg::WORD_W-1:0]    rsp_respond_opcode,
   output logic [sda_pkg::WORD_W-1:0]    rsp_respond_cmd_seq,
   output logic [sda_pkg::CODE_W-1:0]    rsp_respond_code,
   output logic                          rsp_dispatch_valid,
   output logic [sda_pkg::IDX_W-1:0]     rsp_dispatch_index,
   output logic [sda_pkg::TAG_W-1:0]     rsp_dispatch_sequence_id,
   output logic [sda_pkg::CODE_W-1:0]    rsp_warning,
   output logic [sda_pkg::AVAIL_W-1:0]   rsp_available_count,
   output logic [sda_pkg::WORD_W-1:0]    rsp_dispatched_count,
   output logic [sda_pkg::WORD_W-1:0]    rsp_error_count
);
   import sda_pkg::*;

   dp_cmd_type cmd;

   sda_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   sda_datapath #(
      .NUM_SEQUENCERS (NUM_SEQUENCERS)
   ) u_datapath (
      .clock                    (clock),
      .reset                    (reset),
      .cmd                      (cmd),
      .csr_write_enable         (csr_write_enable),
      .csr_write_data           (csr_write_data),
      .req_mode                 (req_mode),
      .req_opcode               (req_opcode),
      .req_cmd_seq              (req_cmd_seq),
      .req_sequence_id          (req_sequence_id),
      .req_wait_for_done        (req_wait_for_done),
      .req_sequencer_index      (req_sequencer_index),
      .req_done_response        (req_done_response),
      .rsp_respond_valid        (rsp_respond_valid),
      .rsp_respond_opcode       (rsp_respond_opcode),
      .rsp_respond_cmd_seq      (rsp_respond_cmd_seq),
      .rsp_respond_code         (rsp_respond_code),
      .rsp_dispatch_valid       (rsp_dispatch_valid),
      .rsp_dispatch_index       (rsp_dispatch_index),
      .rsp_dispatch_sequence_id (rsp_dispatch_sequence_id),
      .rsp_warning              (rsp_warning),
      .rsp_available_count      (rsp_available_count),
      .rsp_dispatched_count     (rsp_dispatched_count),
      .rsp_error_count          (rsp_error_count)
   );

endmodule

[hdl/sda_ctrl.sv]
// Controller state machine: sequences capture, table scan, update and response transfer.
module sda_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output sda_pkg::dp_cmd_type cmd
);
   import sda_pkg::*;

   ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_stall   = 1'b1;
      rsp_valid   = 1'b0;
      case (state_ff)
         CTL_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = CTL_SCAN;
            end
         end
         CTL_SCAN: begin
            cmd.scan = 1'b1;
            state_in = CTL_APPLY;
         end
         CTL_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = CTL_SEND;
         end
         CTL_SEND: begin
            rsp_valid = 1'b1;
            // hold the result until the receiver takes the transfer
            if (!rsp_stall) begin
               state_in = CTL_IDLE;
            end
         end
         default: begin
            state_in = CTL_IDLE;
         end
      endcase
   end

endmodule

[hdl/sda_datapath.sv]
// Datapath: input capture, sequencer table, free search, counters and result registers.
module sda_datapath #(
   parameter int NUM_SEQUENCERS = sda_pkg::NUM_SEQUENCERS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sda_pkg::dp_cmd_type           cmd,
   input  logic                          csr_write_enable,
   input  logic [sda_pkg::MASK_W-1:0]    csr_write_data,
   input  logic [1:0]                    req_mode,
   input  logic [sda_pkg::WORD_W-1:0]    req_opcode,
   input  logic [sda_pkg::WORD_W-1:0]    req_cmd_seq,
   input  logic [sda_pkg::TAG_W-1:0]     req_sequence_id,
   input  logic                          req_wait_for_done,
   input  logic [sda_pkg::IDX_W-1:0]     req_sequencer_index,
   input  logic [sda_pkg::CODE_W-1:0]    req_done_response,
   output logic                          rsp_respond_valid,
   output logic [sda_pkg::WORD_W-1:0]    rsp_respond_opcode,
   output logic [sda_pkg::WORD_W-1:0]    rsp_respond_cmd_seq,
   output logic [sda_pkg::CODE_W-1:0]    rsp_respond_code,
   output logic                          rsp_dispatch_valid,
   output logic [sda_pkg::IDX_W-1:0]     rsp_dispatch_index,
   output logic [sda_pkg::TAG_W-1:0]     rsp_dispatch_sequence_id,
   output logic [sda_pkg::CODE_W-1:0]    rsp_warning,
   output logic [sda_pkg::AVAIL_W-1:0]   rsp_available_count,
   output logic [sda_pkg::WORD_W-1:0]    rsp_dispatched_count,
   output logic [sda_pkg::WORD_W-1:0]    rsp_error_count
);
   import sda_pkg::*;

   localparam int ENTRIES = (NUM_SEQUENCERS < MAX_PORTS) ? NUM_SEQUENCERS : MAX_PORTS;
   localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(NUM_SEQUENCERS + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(NUM_SEQUENCERS);

   // configuration
   logic [MASK_W-1:0] mask_ff;

   // captured request
   mode_type          mode_ff;
   logic [WORD_W-1:0] opc_ff, cseq_ff;
   logic [TAG_W-1:0]  tag_ff;
   logic              block_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [CODE_W-1:0] resp_ff;

   // sequencer table
   entry_state_type   status_ff [ENTRIES];
   entry_state_type   status_in [ENTRIES];
   logic [TAG_W-1:0]  seq_ff [ENTRIES];
   logic [TAG_W-1:0]  seq_in [ENTRIES];
   logic [WORD_W-1:0] ent_opc_ff [ENTRIES];
   logic [WORD_W-1:0] ent_cmd_ff [ENTRIES];

   logic [CW-1:0]     free_ff, free_in;
   logic [WORD_W-1:0] disp_total_ff, disp_total_in;
   logic [WORD_W-1:0] fail_total_ff, fail_total_in;

   // scan stage
   logic              found_comb;
   logic [IDX_W-1:0]  pick_comb;
   logic              idx_ok_comb;
   logic              found_ff;
   logic [IDX_W-1:0]  pick_ff;
   logic              idx_ok_ff;
   entry_state_type   rd_status_ff;
   logic [TAG_W-1:0]  rd_seq_ff;
   logic [WORD_W-1:0] rd_opc_ff, rd_cmd_ff;

   // result registers
   logic              r_rvalid_ff, r_rvalid_in;
   logic [WORD_W-1:0] r_ropc_ff, r_ropc_in;
   logic [WORD_W-1:0] r_rcseq_ff, r_rcseq_in;
   logic [CODE_W-1:0] r_rcode_ff, r_rcode_in;
   logic              r_dvalid_ff, r_dvalid_in;
   logic [IDX_W-1:0]  r_didx_ff, r_didx_in;
   logic [TAG_W-1:0]  r_dtag_ff, r_dtag_in;
   logic [CODE_W-1:0] r_warn_ff, r_warn_in;

   logic              save_cmd;
   logic [CW+AVAIL_W-1:0] free_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '1;
      end else if (csr_write_enable) begin
         mask_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff  <= mode_type'(req_mode);
         opc_ff   <= req_opcode;
         cseq_ff  <= req_cmd_seq;
         tag_ff   <= req_sequence_id;
         block_ff <= req_wait_for_done;
         idx_ff   <= req_sequencer_index;
         resp_ff  <= req_done_response;
      end
   end

   // lowest-numbered connected idle sequencer
   always_comb begin
      found_comb = 1'b0;
      pick_comb  = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (mask_ff[i] && status_ff[i] == ST_IDLE) begin
            found_comb = 1'b1;
            pick_comb  = IDX_W'(i);
         end
      end
   end

   assign idx_ok_comb = ({{(WORD_W-IDX_W){1'b0}}, idx_ff} < WORD_W'(ENTRIES));

   always_ff @(posedge clock) begin
      if (cmd.scan) begin
         found_ff  <= found_comb;
         pick_ff   <= pick_comb;
         idx_ok_ff <= idx_ok_comb;
         if (idx_ok_comb) begin
            rd_status_ff <= status_ff[idx_ff[EW-1:0]];
            rd_seq_ff    <= seq_ff[idx_ff[EW-1:0]];
            rd_opc_ff    <= ent_opc_ff[idx_ff[EW-1:0]];
            rd_cmd_ff    <= ent_cmd_ff[idx_ff[EW-1:0]];
         end else begin
            rd_status_ff <= ST_IDLE;
            rd_seq_ff    <= '0;
            rd_opc_ff    <= '0;
            rd_cmd_ff    <= '0;
         end
      end
   end

   always_comb begin
      status_in     = status_ff;
      seq_in        = seq_ff;
      free_in       = free_ff;
      disp_total_in = disp_total_ff;
      fail_total_in = fail_total_ff;
      save_cmd      = 1'b0;
      r_rvalid_in   = 1'b0;
      r_ropc_in     = '0;
      r_rcseq_in    = '0;
      r_rcode_in    = RESP_OK;
      r_dvalid_in   = 1'b0;
      r_didx_in     = '0;
      r_dtag_in     = '0;
      r_warn_in     = WARN_NONE;
      case (mode_ff)
         MODE_RUN, MODE_RUN_NORSP: begin
            if (!found_ff) begin
               r_warn_in = WARN_NO_SEQ;
               if (mode_ff == MODE_RUN) begin
                  r_rvalid_in = 1'b1;
                  r_ropc_in   = opc_ff;
                  r_rcseq_in  = cseq_ff;
                  r_rcode_in  = RESP_EXEC_ERR;
               end
            end else begin
               save_cmd = (mode_ff == MODE_RUN) && block_ff;
               status_in[pick_ff[EW-1:0]] = save_cmd ? ST_RUN_BLOCK : ST_RUN_FREE;
               seq_in[pick_ff[EW-1:0]]    = tag_ff;
               if (free_ff != '0) begin
                  free_in = free_ff - 1'b1;
               end
               disp_total_in = disp_total_ff + 1'b1;
               r_dvalid_in   = 1'b1;
               r_didx_in     = pick_ff;
               r_dtag_in     = tag_ff;
               // non-blocking run command answers at once
               if (!save_cmd && mode_ff == MODE_RUN) begin
                  r_rvalid_in = 1'b1;
                  r_ropc_in   = opc_ff;
                  r_rcseq_in  = cseq_ff;
                  r_rcode_in  = RESP_OK;
               end
            end
         end
         MODE_STARTED: begin
            if (idx_ok_ff) begin
               if (rd_status_ff != ST_IDLE) begin
                  if (rd_seq_ff != tag_ff) begin
                     r_warn_in = WARN_CONFLICT;
                     seq_in[idx_ff[EW-1:0]] = tag_ff;
                  end
               end else begin
                  r_warn_in = WARN_UNEXPECTED;
                  status_in[idx_ff[EW-1:0]] = ST_RUN_FREE;
                  seq_in[idx_ff[EW-1:0]]    = tag_ff;
                  if (free_ff != '0) begin
                     free_in = free_ff - 1'b1;
                  end
               end
            end
         end
         MODE_DONE: begin
            if (idx_ok_ff) begin
               if (rd_status_ff == ST_RUN_BLOCK) begin
                  r_rvalid_in = 1'b1;
                  r_ropc_in   = rd_opc_ff;
                  r_rcseq_in  = rd_cmd_ff;
                  r_rcode_in  = resp_ff;
                  if (resp_ff == RESP_EXEC_ERR) begin
                     fail_total_in = fail_total_ff + 1'b1;
                  end
               end else if (rd_status_ff != ST_RUN_FREE) begin
                  r_warn_in = WARN_UNKNOWN_FIN;
               end
               status_in[idx_ff[EW-1:0]] = ST_IDLE;
               seq_in[idx_ff[EW-1:0]]    = '0;
               if (free_ff < FULL_COUNT) begin
                  free_in = free_ff + 1'b1;
               end
            end
         end
         default: begin
            r_warn_in = WARN_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            status_ff[i] <= ST_IDLE;
            seq_ff[i]    <= '0;
         end
         free_ff       <= FULL_COUNT;
         disp_total_ff <= '0;
         fail_total_ff <= '0;
      end else if (cmd.apply) begin
         status_ff     <= status_in;
         seq_ff        <= seq_in;
         free_ff       <= free_in;
         disp_total_ff <= disp_total_in;
         fail_total_ff <= fail_total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.apply && save_cmd) begin
         ent_opc_ff[pick_ff[EW-1:0]] <= opc_ff;
         ent_cmd_ff[pick_ff[EW-1:0]] <= cseq_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.apply) begin
         r_rvalid_ff <= r_rvalid_in;
         r_ropc_ff   <= r_ropc_in;
         r_rcseq_ff  <= r_rcseq_in;
         r_rcode_ff  <= r_rcode_in;
         r_dvalid_ff <= r_dvalid_in;
         r_didx_ff   <= r_didx_in;
         r_dtag_ff   <= r_dtag_in;
         r_warn_ff   <= r_warn_in;
      end
   end

   assign free_ext = {{AVAIL_W{1'b0}}, free_ff};

   assign rsp_respond_valid        = r_rvalid_ff;
   assign rsp_respond_opcode       = r_ropc_ff;
   assign rsp_respond_cmd_seq      = r_rcseq_ff;
   assign rsp_respond_code         = r_rcode_ff;
   assign rsp_dispatch_valid       = r_dvalid_ff;
   assign rsp_dispatch_index       = r_didx_ff;
   assign rsp_dispatch_sequence_id = r_dtag_ff;
   assign rsp_warning              = r_warn_ff;
   assign rsp_available_count      = free_ext[AVAIL_W-1:0];
   assign rsp_dispatched_count     = disp_total_ff;
   assign rsp_error_count          = fail_total_ff;

endmodule
